// File: rtl/kfsi_pkg.sv
// Types and constants shared by the keyframe servo interpolator modules.
// No dependencies.
`default_nettype none
package kfsi_pkg;

  localparam int SV_W    = 5;
  localparam int KEY_W   = 6;
  localparam int POS_W   = 8;
  localparam int FRM_W   = 16;
  localparam int TRQ_W   = 8;
  localparam int ANG_W   = 17;
  localparam int MAG_W   = 24;
  localparam int STEP_W  = 25;
  localparam int QSHIFT  = 16;
  localparam int CFG_IW  = 1;
  localparam int CFG_DW  = 6;
  localparam int DIV_DW  = 24;
  localparam int DIV_VW  = 16;
  localparam int DIV_CW  = 5;

  localparam logic [MAG_W-1:0] STEP_LIM = MAG_W'(253 << QSHIFT);
  localparam logic [MAG_W-1:0] STEP_SAT = MAG_W'(254 << QSHIFT);
  localparam int POS_MAX   = 254;
  localparam int POS_MIN   = 1;
  localparam int POS_MID   = 127;
  localparam int ANG_SCALE = 270;

  typedef enum logic [1:0] {
    MODE_KEY   = 2'd0,
    MODE_HDR   = 2'd1,
    MODE_START = 2'd2,
    MODE_TICK  = 2'd3
  } mode_t;

  localparam logic [CFG_IW-1:0] CFG_SCENES = 1'b0;
  localparam logic [CFG_IW-1:0] CFG_SERVOS = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_TDEC, S_SRD, S_SDIFF, S_SDIV, S_SWR, S_IV, S_IVW,
    S_ERD, S_EMUL, S_ESUM, S_EOUT, S_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_ACCEPT, OP_NEXT_FRAME, OP_NEXT_SCENE, OP_FINISH,
    OP_SDIV_START, OP_SWRITE, OP_IDIV_START, OP_ILATCH, OP_EMUL,
    OP_ESUM, OP_EADV
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_fin;
  } cmd_t;

  typedef struct packed {
    logic playing;
    logic frame_more;
    logic scene_more;
    logic div_done;
    logic step_end;
    logic emit_end;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/kfsi_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on kfsi_pkg.
`default_nettype none
module kfsi_div (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           start,
  input  wire [kfsi_pkg::DIV_DW-1:0]    dividend,
  input  wire [kfsi_pkg::DIV_VW-1:0]    divisor,
  output logic [kfsi_pkg::DIV_DW-1:0]   quotient,
  output logic                          done
);
  import kfsi_pkg::*;

  logic [DIV_DW-1:0] quo_r, quo_nxt;
  logic [DIV_VW:0]   rem_r, rem_nxt;
  logic [DIV_VW-1:0] dvs_r, dvs_nxt;
  logic [DIV_CW-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic [DIV_VW:0]   rsh;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    rsh      = {rem_r[DIV_VW-1:0], quo_r[DIV_DW-1]};
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = DIV_CW'(DIV_DW - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rsh >= {1'b0, dvs_r}) begin
        rem_nxt = rsh - {1'b0, dvs_r};
        quo_nxt = {quo_r[DIV_DW-2:0], 1'b1};
      end else begin
        rem_nxt = rsh;
        quo_nxt = {quo_r[DIV_DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  assign quotient = quo_r;
  assign done     = ~busy_r;
endmodule
`default_nettype wire

// File: rtl/kfsi_ctrl.sv
// Sequencing state machine of the interpolator.
// Depends on kfsi_pkg.
`default_nettype none
module kfsi_ctrl (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  input  wire [1:0]          in_mode,
  input  wire                out_ready,
  input  wire kfsi_pkg::status_t st,
  output logic               in_ready,
  output logic               out_valid,
  output kfsi_pkg::cmd_t     cmd
);
  import kfsi_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_START) begin
            state_nxt = S_SRD;
          end else if (in_mode == MODE_TICK && st.playing) begin
            state_nxt = S_TDEC;
          end
        end
      end
      S_TDEC: begin
        if (st.frame_more) begin
          state_nxt = S_IV;
        end else if (st.scene_more) begin
          state_nxt = S_SRD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_SRD:   state_nxt = S_SDIFF;
      S_SDIFF: state_nxt = S_SDIV;
      S_SDIV: begin
        if (st.div_done) begin
          state_nxt = S_SWR;
        end
      end
      S_SWR:   state_nxt = st.step_end ? S_IV : S_SRD;
      S_IV:    state_nxt = S_IVW;
      S_IVW: begin
        if (st.div_done) begin
          state_nxt = S_ERD;
        end
      end
      S_ERD:   state_nxt = S_EMUL;
      S_EMUL:  state_nxt = S_ESUM;
      S_ESUM:  state_nxt = S_EOUT;
      S_EOUT: begin
        if (out_ready) begin
          state_nxt = st.emit_end ? S_IDLE : S_ERD;
        end
      end
      S_FIN: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    out_valid   = 1'b0;
    cmd.op      = OP_NONE;
    cmd.out_fin = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
        end
      end
      S_TDEC: begin
        if (st.frame_more) begin
          cmd.op = OP_NEXT_FRAME;
        end else if (st.scene_more) begin
          cmd.op = OP_NEXT_SCENE;
        end else begin
          cmd.op = OP_FINISH;
        end
      end
      S_SDIFF: cmd.op = OP_SDIV_START;
      S_SWR:   cmd.op = OP_SWRITE;
      S_IV:    cmd.op = OP_IDIV_START;
      S_IVW: begin
        if (st.div_done) begin
          cmd.op = OP_ILATCH;
        end
      end
      S_EMUL:  cmd.op = OP_EMUL;
      S_ESUM:  cmd.op = OP_ESUM;
      S_EOUT: begin
        out_valid = 1'b1;
        if (out_ready && !st.emit_end) begin
          cmd.op = OP_EADV;
        end
      end
      S_FIN: begin
        out_valid   = 1'b1;
        cmd.out_fin = 1'b1;
      end
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule
`default_nettype wire

// File: rtl/kfsi_dp.sv
// Datapath: keyframe and scene stores, step sizes, playback counters and result fields.
// Depends on kfsi_pkg and kfsi_div.
`default_nettype none
module kfsi_dp #(
  parameter int SERVOS = 31,
  parameter int SCENES = 32
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire kfsi_pkg::cmd_t              cmd,
  output kfsi_pkg::status_t                st,
  input  wire                              cfg_we,
  input  wire [kfsi_pkg::CFG_IW-1:0]       cfg_index,
  input  wire [kfsi_pkg::CFG_DW-1:0]       cfg_wdata,
  input  wire [1:0]                        in_mode,
  input  wire [kfsi_pkg::KEY_W-1:0]        in_key_index,
  input  wire [kfsi_pkg::SV_W-1:0]         in_servo_index,
  input  wire [kfsi_pkg::POS_W-1:0]        in_position,
  input  wire [kfsi_pkg::FRM_W-1:0]        in_frames,
  input  wire [kfsi_pkg::FRM_W-1:0]        in_run_time,
  input  wire [kfsi_pkg::TRQ_W-1:0]        in_torque,
  output logic [kfsi_pkg::SV_W-1:0]        out_servo_channel,
  output logic [kfsi_pkg::POS_W-1:0]       out_clamped_position,
  output logic signed [kfsi_pkg::ANG_W-1:0] out_angle,
  output logic [kfsi_pkg::TRQ_W-1:0]       out_scene_torque,
  output logic [kfsi_pkg::FRM_W-1:0]       out_frame_interval,
  output logic [4:0]                       out_scene_number,
  output logic [kfsi_pkg::FRM_W-1:0]       out_frame_number,
  output logic                             out_last,
  output logic                             out_finished
);
  import kfsi_pkg::*;

  localparam int KD  = (SCENES + 1) * SERVOS;
  localparam int KAW = KD > 1 ? $clog2(KD) : 1;
  localparam int SCW = SCENES > 1 ? $clog2(SCENES) : 1;
  localparam int IW  = SERVOS > 1 ? $clog2(SERVOS) : 1;

  logic [POS_W-1:0]  kf_mem [KD];
  logic [FRM_W-1:0]  frm_mem [SCENES];
  logic [FRM_W-1:0]  run_mem [SCENES];
  logic [TRQ_W-1:0]  trq_mem [SCENES];
  logic [STEP_W-1:0] step_mem [SERVOS];

  logic [POS_W-1:0]  kf_a_q, kf_b_q;
  logic [FRM_W-1:0]  frm_q, run_q;
  logic [TRQ_W-1:0]  trq_q;
  logic [STEP_W-1:0] step_q;

  logic [SCW-1:0]    scene_r, scene_nxt;
  logic [FRM_W-1:0]  frame_r, frame_nxt;
  logic              playing_r, playing_nxt;
  logic [SV_W-1:0]   i_r, i_nxt;
  logic [KEY_W-1:0]  scene_count_r;
  logic [SV_W-1:0]   servo_count_r;

  logic              sneg_r;
  logic [FRM_W-1:0]  interval_r;
  logic [31:0]       pp_lo_r;
  logic [23:0]       pp_hi_r;
  logic [POS_W-1:0]  pos_r;

  logic              accept, key_ok, hdr_ok;
  logic [KAW-1:0]    load_addr, cur_addr, next_addr;
  logic [FRM_W-1:0]  eff_f;
  logic [6:0]        sc7, eff_sc;
  logic [SV_W-1:0]   eff_sv;
  logic signed [POS_W:0] diff;
  logic [POS_W-1:0]  dmag;

  logic              div_start, div_done;
  logic [DIV_DW-1:0] div_dvd, div_quo;
  logic [MAG_W-1:0]  qclamp;

  logic [24:0]       off;
  logic signed [26:0] pos_full;
  logic [POS_W-1:0]  pos_c;
  logic signed [POS_W:0] pdelta;

  assign accept    = (cmd.op == OP_ACCEPT);
  assign key_ok    = ({1'b0, in_key_index} <= 7'(SCENES)) && (in_servo_index < SV_W'(SERVOS));
  assign hdr_ok    = ({1'b0, in_key_index} < 7'(SCENES));
  assign load_addr = KAW'(KAW'(in_key_index) * KAW'(SERVOS)) + KAW'(in_servo_index);
  assign cur_addr  = KAW'(KAW'(scene_r) * KAW'(SERVOS)) + KAW'(i_r);
  assign next_addr = KAW'((KAW'(scene_r) + 1'b1) * KAW'(SERVOS)) + KAW'(i_r);

  always_ff @(posedge clk) begin
    if (accept && in_mode == MODE_KEY && key_ok) begin
      kf_mem[load_addr] <= in_position;
    end
    kf_a_q <= kf_mem[cur_addr];
    kf_b_q <= kf_mem[next_addr];
  end

  always_ff @(posedge clk) begin
    if (accept && in_mode == MODE_HDR && hdr_ok) begin
      frm_mem[in_key_index[SCW-1:0]] <= in_frames;
      run_mem[in_key_index[SCW-1:0]] <= in_run_time;
      trq_mem[in_key_index[SCW-1:0]] <= in_torque;
    end
    frm_q <= frm_mem[scene_r];
    run_q <= run_mem[scene_r];
    trq_q <= trq_mem[scene_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SWRITE) begin
      step_mem[i_r[IW-1:0]] <= {sneg_r, qclamp};
    end
    step_q <= step_mem[i_r[IW-1:0]];
  end

  assign eff_f  = (frm_q == '0) ? FRM_W'(1) : frm_q;
  assign sc7    = {1'b0, scene_count_r};
  assign eff_sc = (sc7 == '0) ? 7'd1 : ((sc7 > 7'(SCENES)) ? 7'(SCENES) : sc7);
  assign eff_sv = (servo_count_r == '0) ? SV_W'(1) :
                  ((servo_count_r > SV_W'(SERVOS)) ? SV_W'(SERVOS) : servo_count_r);

  assign diff = $signed({1'b0, kf_b_q}) - $signed({1'b0, kf_a_q});
  assign dmag = diff[POS_W] ? POS_W'(-diff) : diff[POS_W-1:0];

  assign div_start = (cmd.op == OP_SDIV_START) || (cmd.op == OP_IDIV_START);
  assign div_dvd   = (cmd.op == OP_SDIV_START) ? {dmag, 16'b0} : DIV_DW'(run_q);
  assign qclamp    = (div_quo > STEP_LIM) ? STEP_SAT : div_quo;

  kfsi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (eff_f),
    .quotient (div_quo),
    .done     (div_done)
  );

  assign off      = 25'(pp_hi_r) + 25'(pp_lo_r[31:QSHIFT]);
  assign pos_full = step_q[STEP_W-1] ? ($signed({19'b0, kf_a_q}) - $signed({2'b0, off}))
                                     : ($signed({19'b0, kf_a_q}) + $signed({2'b0, off}));
  assign pos_c    = (pos_full > 27'sd254) ? POS_W'(POS_MAX) :
                    ((pos_full < 27'sd1) ? POS_W'(POS_MIN) : pos_full[POS_W-1:0]);

  always_comb begin
    scene_nxt   = scene_r;
    frame_nxt   = frame_r;
    playing_nxt = playing_r;
    i_nxt       = i_r;
    case (cmd.op)
      OP_ACCEPT: begin
        if (in_mode == MODE_START) begin
          scene_nxt   = '0;
          frame_nxt   = '0;
          playing_nxt = 1'b1;
          i_nxt       = '0;
        end
      end
      OP_NEXT_FRAME: frame_nxt = frame_r + 1'b1;
      OP_NEXT_SCENE: begin
        scene_nxt = scene_r + 1'b1;
        frame_nxt = '0;
        i_nxt     = '0;
      end
      OP_FINISH: begin
        playing_nxt = 1'b0;
        frame_nxt   = '0;
      end
      OP_SWRITE: i_nxt = i_r + 1'b1;
      OP_ILATCH: i_nxt = '0;
      OP_EADV:   i_nxt = i_r + 1'b1;
      default:   i_nxt = i_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scene_r       <= '0;
      frame_r       <= '0;
      playing_r     <= 1'b0;
      i_r           <= '0;
      scene_count_r <= KEY_W'(1);
      servo_count_r <= SV_W'(31);
    end else begin
      scene_r   <= scene_nxt;
      frame_r   <= frame_nxt;
      playing_r <= playing_nxt;
      i_r       <= i_nxt;
      if (cfg_we && cfg_index == CFG_SCENES) begin
        scene_count_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_SERVOS) begin
        servo_count_r <= cfg_wdata[SV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SDIV_START) begin
      sneg_r <= diff[POS_W];
    end
    if (cmd.op == OP_ILATCH) begin
      interval_r <= div_quo[FRM_W-1:0];
    end
    if (cmd.op == OP_EMUL) begin
      pp_lo_r <= step_q[15:0] * frame_r;
      pp_hi_r <= step_q[23:16] * frame_r;
    end
    if (cmd.op == OP_ESUM) begin
      pos_r <= pos_c;
    end
  end

  assign st.playing    = playing_r;
  assign st.frame_more = {1'b0, frame_r} < ({1'b0, eff_f} - 17'd1);
  assign st.scene_more = 7'(scene_r) < (eff_sc - 7'd1);
  assign st.div_done   = div_done;
  assign st.step_end   = (i_r == SV_W'(SERVOS - 1));
  assign st.emit_end   = (i_r == eff_sv - 1'b1);

  assign pdelta = $signed({1'b0, pos_r}) - 9'sd127;

  always_comb begin
    if (cmd.out_fin) begin
      out_servo_channel    = '0;
      out_clamped_position = '0;
      out_angle            = '0;
      out_scene_torque     = '0;
      out_frame_interval   = '0;
      out_scene_number     = '0;
      out_frame_number     = '0;
      out_last             = 1'b1;
      out_finished         = 1'b1;
    end else begin
      out_servo_channel    = i_r;
      out_clamped_position = pos_r;
      out_angle            = ANG_W'(pdelta) * ANG_W'(ANG_SCALE);
      out_scene_torque     = trq_q;
      out_frame_interval   = interval_r;
      out_scene_number     = 5'(scene_r);
      out_frame_number     = frame_r;
      out_last             = st.emit_end;
      out_finished         = 1'b0;
    end
  end
endmodule
`default_nettype wire

// File: rtl/keyframe_servo_interpolator.sv
// Keyframe servo interpolator top level: controller, datapath and assertions.
// Depends on kfsi_pkg, kfsi_ctrl and kfsi_dp.
// A load is written without leaving idle. A frame tick runs the interval division before
// the first beat, then emits a beat per active servo; a scene start adds the step divisions
// of all SERVOS channels. One item is handled at a time.
// The shared divider yields one bit per cycle. Synchronous reset clears control state.
`default_nettype none
module keyframe_servo_interpolator #(
  parameter int SERVOS = 31,
  parameter int SCENES = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire [kfsi_pkg::CFG_IW-1:0]        cfg_index,
  input  wire [kfsi_pkg::CFG_DW-1:0]        cfg_wdata,
  input  wire                               in_valid,
  output logic                              in_ready,
  input  wire [1:0]                         in_mode,
  input  wire [kfsi_pkg::KEY_W-1:0]         in_key_index,
  input  wire [kfsi_pkg::SV_W-1:0]          in_servo_index,
  input  wire [kfsi_pkg::POS_W-1:0]         in_position,
  input  wire [kfsi_pkg::FRM_W-1:0]         in_frames,
  input  wire [kfsi_pkg::FRM_W-1:0]         in_run_time,
  input  wire [kfsi_pkg::TRQ_W-1:0]         in_torque,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [kfsi_pkg::SV_W-1:0]         out_servo_channel,
  output logic [kfsi_pkg::POS_W-1:0]        out_clamped_position,
  output logic signed [kfsi_pkg::ANG_W-1:0] out_angle,
  output logic [kfsi_pkg::TRQ_W-1:0]        out_scene_torque,
  output logic [kfsi_pkg::FRM_W-1:0]        out_frame_interval,
  output logic [4:0]                        out_scene_number,
  output logic [kfsi_pkg::FRM_W-1:0]        out_frame_number,
  output logic                              out_last,
  output logic                              out_finished
);
  import kfsi_pkg::*;

  cmd_t    cmd;
  status_t st;

  kfsi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .out_ready (out_ready),
    .st        (st),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  kfsi_dp #(
    .SERVOS (SERVOS),
    .SCENES (SCENES)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_mode              (in_mode),
    .in_key_index         (in_key_index),
    .in_servo_index       (in_servo_index),
    .in_position          (in_position),
    .in_frames            (in_frames),
    .in_run_time          (in_run_time),
    .in_torque            (in_torque),
    .out_servo_channel    (out_servo_channel),
    .out_clamped_position (out_clamped_position),
    .out_angle            (out_angle),
    .out_scene_torque     (out_scene_torque),
    .out_frame_interval   (out_frame_interval),
    .out_scene_number     (out_scene_number),
    .out_frame_number     (out_frame_number),
    .out_last             (out_last),
    .out_finished         (out_finished)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input taken while a beat is pending");

  a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_last && out_clamped_position == '0)
    else $error("finished beat malformed");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> out_clamped_position >= 8'd1 &&
                                   out_clamped_position <= 8'd254)
    else $error("position out of range");

  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_finished |-> out_servo_channel < 5'(SERVOS))
    else $error("servo channel out of range");

endmodule
`default_nettype wire
